>>> sv/arpu_pkg.sv
// Package: command codes, S-box tables and GF(2^8) helpers for the AES round unit.
`default_nettype none
package arpu_pkg;

   typedef enum logic [2:0] {
      CMD_SUB       = 3'd0,
      CMD_INV_SUB   = 3'd1,
      CMD_SHIFT     = 3'd2,
      CMD_INV_SHIFT = 3'd3,
      CMD_MIX       = 3'd4,
      CMD_INV_MIX   = 3'd5,
      CMD_ADD_KEY   = 3'd6,
      CMD_PASS      = 3'd7
   } cmd_type;

   localparam int LANES = 4;

   typedef logic [7:0] byte_type;
   typedef byte_type [3:0] column_type;
   typedef byte_type [15:0] block_type;

   localparam logic [7:0] GF_POLY = 8'h1b;

   localparam logic [7:0] FWD_SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] gf_dbl(input logic [7:0] v);
      gf_dbl = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

endpackage
`default_nettype wire

>>> sv/aes_round_primitive_unit.sv
// Top level of the AES round primitive unit.
// Usage:
//  - Input channel req_*: one beat carries a command, a 128-bit state and a
//    128-bit round key. Commands: SubBytes, inverse SubBytes, ShiftRows,
//    inverse ShiftRows, MixColumns, inverse MixColumns, AddRoundKey; code 7
//    passes the state through.
//  - Result channel rsp_*: one beat per input beat carrying the new state.
//  - Four column lanes work side by side (S-box, mix, key add); the merge
//    stage does the cross-column row shifts and registers the result.
//  - rsp_tvalid rises in the cycle after an input beat is accepted.
//  - Throughput: one beat per cycle while rsp_tready is high, set by the single output register.
//  - A held result does not block input when rsp_tready is high that cycle;
//    with rsp_tready low the output register holds and req_tready drops.
//  - Reset clears the output valid flag; the result register is not reset.
`default_nettype none
module aes_round_primitive_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // state_low[63:0], state_high[127:64], key_low[191:128], key_high[255:192]
   input  wire [255:0]  req_tdata,
   // command[2:0]
   input  wire [2:0]    req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // result_low[63:0], result_high[127:64]
   output logic [127:0] rsp_tdata
);

   arpu_pkg::cmd_type   cmd;
   arpu_pkg::block_type state, key, lane_out, result;

   assign cmd   = arpu_pkg::cmd_type'(req_tuser);
   assign state = req_tdata[127:0];
   assign key   = req_tdata[255:128];

   for (genvar g = 0; g < arpu_pkg::LANES; g++) begin : g_lane
      arpu_lane u_lane (
         .cmd     (cmd),
         .col     (state[4*g +: 4]),
         .key     (key[4*g +: 4]),
         .col_out (lane_out[4*g +: 4])
      );
   end

   arpu_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .cmd       (cmd),
      .state     (state),
      .lane_out  (lane_out),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = result;

endmodule
`default_nettype wire

>>> sv/arpu_lane.sv
// One column lane: S-box lookups, MixColumns and key add on four bytes.
`default_nettype none
module arpu_lane (
   input  wire arpu_pkg::cmd_type    cmd,
   input  wire arpu_pkg::column_type col,
   input  wire arpu_pkg::column_type key,
   output arpu_pkg::column_type      col_out
);

   arpu_pkg::column_type x2, x4, x8, fwd_mix, inv_mix;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         x2[r] = arpu_pkg::gf_dbl(col[r]);
         x4[r] = arpu_pkg::gf_dbl(x2[r]);
         x8[r] = arpu_pkg::gf_dbl(x4[r]);
      end
      // row r weights: forward {2,3,1,1}, inverse {14,11,13,9}, rotated by r
      for (int r = 0; r < 4; r++) begin
         fwd_mix[r] = x2[r] ^ (x2[(r+1)%4] ^ col[(r+1)%4]) ^ col[(r+2)%4] ^ col[(r+3)%4];
         inv_mix[r] = (x8[r] ^ x4[r] ^ x2[r])
                    ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ col[(r+1)%4])
                    ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ col[(r+2)%4])
                    ^ (x8[(r+3)%4] ^ col[(r+3)%4]);
      end
      for (int r = 0; r < 4; r++) begin
         case (cmd)
            arpu_pkg::CMD_SUB:     col_out[r] = arpu_pkg::FWD_SBOX[col[r]];
            arpu_pkg::CMD_INV_SUB: col_out[r] = arpu_pkg::INV_SBOX[col[r]];
            arpu_pkg::CMD_MIX:     col_out[r] = fwd_mix[r];
            arpu_pkg::CMD_INV_MIX: col_out[r] = inv_mix[r];
            arpu_pkg::CMD_ADD_KEY: col_out[r] = col[r] ^ key[r];
            default:               col_out[r] = col[r];
         endcase
      end
   end

endmodule
`default_nettype wire

>>> sv/arpu_merge.sv
// Merge stage: row shifts across lanes, picks lane results, output register.
`default_nettype none
module arpu_merge (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  wire arpu_pkg::cmd_type   cmd,
   input  wire arpu_pkg::block_type state,
   input  wire arpu_pkg::block_type lane_out,
   output logic                     out_valid,
   input  wire                      out_ready,
   output arpu_pkg::block_type      out_data
);

   arpu_pkg::block_type shifted, result_in, result_ff;
   logic valid_ff, valid_in;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (cmd == arpu_pkg::CMD_SHIFT) begin
               shifted[r + 4*c] = state[r + 4*((c + r) % 4)];
            end else begin
               shifted[r + 4*c] = state[r + 4*((c + 4 - r) % 4)];
            end
         end
      end
      case (cmd) inside
         arpu_pkg::CMD_SHIFT, arpu_pkg::CMD_INV_SHIFT: result_in = shifted;
         default:                                      result_in = lane_out;
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         result_ff <= result_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/arpu_checker.sv
// Port-level checker for the AES round unit, bound to the top level.
`default_nettype none
module arpu_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [127:0] rsp_tdata
);

   // a result is valid in the cycle after an accepted beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no result after accepted beat");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // input is ready whenever the output side drains
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input blocked while output drains");

   // without a new beat, a taken result leaves
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !req_tvalid |=> !rsp_tvalid)
      else $error("result repeated");

endmodule

bind aes_round_primitive_unit arpu_checker u_arpu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
